// ===== rtl/core/apef_pkg.sv =====
// Shared types for the audio playback event controller.
// Used by the front, queue, back and top modules. It has no dependencies.
`default_nettype none

package apef_pkg;

   localparam int unsigned CsrDataWidth  = 16;
   localparam int unsigned CsrIndexWidth = 2;

   typedef struct packed {
      logic [3:0]  func;
      logic        agent_on;
      logic        link_up;
      logic [15:0] wait_ticks;
      logic [15:0] stall_count;
   } req_type;

   typedef struct packed {
      logic [3:0] action_kind;
      logic [1:0] station_code;
      logic       indicator_on;
      logic       last;
   } rsp_type;

   // Action sequences that one event can expand into.
   typedef enum logic [2:0] {
      SEQ_START     = 3'd0,
      SEQ_AUTO      = 3'd1,
      SEQ_RESEQ     = 3'd2,
      SEQ_SHOW_CONN = 3'd3,
      SEQ_SHOW_WIFI = 3'd4,
      SEQ_ERR       = 3'd5,
      SEQ_STOP_IND  = 3'd6,
      SEQ_STOP      = 3'd7
   } seq_type;

endpackage

`default_nettype wire

// ===== rtl/core/apef_front.sv =====
// Front end: takes events, runs the playback state machine, holds the CSRs.
// Pushes one sequence code per event that causes actions. Depends on apef_pkg.
`default_nettype none

module apef_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire apef_pkg::req_type                     req_data,
   input  wire logic                                  csr_we,
   input  wire logic [apef_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [apef_pkg::CsrDataWidth-1:0]     csr_wdata,
   output logic                                       q_push,
   output apef_pkg::seq_type                          q_seq,
   input  wire logic                                  q_full
);
   import apef_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_PENDING  = 6'b000010,
      ST_INIT     = 6'b000100,
      ST_PLAYING  = 6'b001000,
      ST_STOPPING = 6'b010000,
      ST_ERROR    = 6'b100000
   } state_type;

   typedef enum logic [3:0] {
      EV_NONE         = 4'd0,
      EV_BTN_TOGGLE   = 4'd1,
      EV_AUTO_PLAY    = 4'd2,
      EV_AGENT_OFF    = 4'd3,
      EV_NET_OK       = 4'd4,
      EV_TICK         = 4'd5,
      EV_PLAYING      = 4'd6,
      EV_PLAYER_ERROR = 4'd7,
      EV_BTN_NEXT     = 4'd8,
      EV_PLAYER_IDLE  = 4'd9,
      EV_PLAYER_NEXT  = 4'd10,
      EV_ALARM_DONE   = 4'd11,
      EV_STOP_DONE    = 4'd12
   } event_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PENDING_TIMEOUT = 2'd0,
      CSR_STALL_LIMIT     = 2'd1
   } csr_type;

   state_type   state_ff, state_in;
   logic [15:0] timeout_ff, limit_ff;
   logic        accept;
   logic        seq_valid;
   seq_type     seq;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign q_push   = accept && seq_valid;
   assign q_seq    = seq;

   always_comb begin
      state_in  = state_ff;
      seq_valid = 1'b0;
      seq       = SEQ_START;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_data.func == EV_BTN_TOGGLE) begin
               if (req_data.agent_on) begin
                  seq_valid = 1'b1;
                  if (req_data.link_up) begin
                     state_in = ST_INIT;
                     seq      = SEQ_START;
                  end else begin
                     state_in = ST_PENDING;
                     seq      = SEQ_SHOW_CONN;
                  end
               end
            end else if (req_data.func == EV_AUTO_PLAY) begin
               state_in  = ST_INIT;
               seq_valid = 1'b1;
               seq       = SEQ_AUTO;
            end
         end
         ST_PENDING: begin
            if (req_data.func == EV_NET_OK) begin
               state_in  = ST_INIT;
               seq_valid = 1'b1;
               seq       = SEQ_START;
            end else if (req_data.func == EV_TICK && req_data.wait_ticks >= timeout_ff) begin
               state_in  = ST_ERROR;
               seq_valid = 1'b1;
               seq       = SEQ_SHOW_WIFI;
            end else if (req_data.func == EV_BTN_TOGGLE) begin
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            if (req_data.func == EV_PLAYING) begin
               state_in = ST_PLAYING;
            end else if (req_data.func == EV_PLAYER_ERROR) begin
               state_in  = ST_ERROR;
               seq_valid = 1'b1;
               seq       = SEQ_ERR;
            end
         end
         ST_PLAYING: begin
            if (req_data.func == EV_BTN_TOGGLE) begin
               state_in  = ST_STOPPING;
               seq_valid = 1'b1;
               seq       = SEQ_STOP_IND;
            end else if (req_data.func == EV_BTN_NEXT || req_data.func == EV_PLAYER_IDLE ||
                         req_data.func == EV_PLAYER_NEXT) begin
               seq_valid = 1'b1;
               seq       = SEQ_RESEQ;
            end else if (req_data.func == EV_PLAYER_ERROR) begin
               state_in  = ST_ERROR;
               seq_valid = 1'b1;
               seq       = SEQ_ERR;
            end else if (req_data.func == EV_ALARM_DONE) begin
               state_in  = ST_STOPPING;
               seq_valid = 1'b1;
               seq       = SEQ_STOP;
            end else if (req_data.func == EV_TICK && req_data.stall_count >= limit_ff) begin
               seq_valid = 1'b1;
               seq       = SEQ_RESEQ;
            end
         end
         ST_STOPPING: begin
            if (req_data.func == EV_STOP_DONE) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERROR: begin
            if (req_data.func == EV_BTN_TOGGLE) begin
               state_in  = ST_INIT;
               seq_valid = 1'b1;
               seq       = SEQ_START;
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 16'd30;
         limit_ff   <= 16'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PENDING_TIMEOUT: timeout_ff <= csr_wdata;
            CSR_STALL_LIMIT:     limit_ff   <= csr_wdata;
            default: begin
               timeout_ff <= timeout_ff;
            end
         endcase
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("push into a full sequence queue");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == CSR_STALL_LIMIT |=> limit_ff == $past(csr_wdata))
      else $error("stall limit write lost");

   a_stop_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STOPPING && !(accept && req_data.func == EV_STOP_DONE)
      |=> state_ff == ST_STOPPING) else $error("stopping state left early");

endmodule

`default_nettype wire

// ===== rtl/core/apef_queue.sv =====
// Short queue of sequence codes between the front and back ends.
// Depends on apef_pkg for the sequence code type.
`default_nettype none

module apef_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire apef_pkg::seq_type push_seq,
   output logic                   full,
   input  wire logic              pop,
   output apef_pkg::seq_type      pop_seq,
   output logic                   empty
);
   import apef_pkg::*;

   localparam int unsigned PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   seq_type                 mem_ff [DEPTH];
   logic [PtrWidth-1:0]     head_ff, tail_ff;
   logic [CountWidth-1:0]   count_ff;

   assign full    = (count_ff == CountWidth'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_seq = mem_ff[head_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= (tail_ff == PtrWidth'(DEPTH - 1)) ? '0 : tail_ff + PtrWidth'(1);
         end
         if (pop) begin
            head_ff <= (head_ff == PtrWidth'(DEPTH - 1)) ? '0 : head_ff + PtrWidth'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CountWidth'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CountWidth'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("queue underflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/apef_back.sv =====
// Back end: expands each sequence code into its actions in a result register, one
// per cycle while that register is empty or being popped. Depends on apef_pkg.
`default_nettype none

module apef_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire apef_pkg::seq_type q_seq,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output apef_pkg::rsp_type      rsp_data
);
   import apef_pkg::*;

   typedef enum logic [3:0] {
      ACT_INIT      = 4'd0,
      ACT_FETCH     = 4'd1,
      ACT_PLAY      = 4'd2,
      ACT_ARM_ALARM = 4'd3,
      ACT_STOP      = 4'd4,
      ACT_DEINIT    = 4'd5,
      ACT_VOLUME    = 4'd6,
      ACT_SHOW      = 4'd7,
      ACT_INDICATOR = 4'd8
   } act_type;

   typedef enum logic [1:0] {
      STN_NONE       = 2'd0,
      STN_CONNECTING = 2'd1,
      STN_WIFI_FAIL  = 2'd2,
      STN_AUDIO_FAIL = 2'd3
   } station_type;

   // Action at position step of the start sequence (init, fetch, play, arm).
   function automatic act_type start_act(input logic [2:0] step);
      act_type a;
      case (step[1:0])
         2'd0:    a = ACT_INIT;
         2'd1:    a = ACT_FETCH;
         2'd2:    a = ACT_PLAY;
         default: a = ACT_ARM_ALARM;
      endcase
      return a;
   endfunction

   function automatic rsp_type action_of(input seq_type s, input logic [2:0] step);
      rsp_type r;
      r              = '0;
      r.station_code = STN_NONE;
      unique case (s)
         SEQ_START: begin
            r.action_kind = start_act(step);
            r.last        = (step == 3'd3);
         end
         SEQ_AUTO: begin
            r.action_kind = (step == 3'd0) ? ACT_VOLUME : start_act(step - 3'd1);
            r.last        = (step == 3'd4);
         end
         SEQ_RESEQ: begin
            if (step == 3'd0) begin
               r.action_kind = ACT_STOP;
            end else if (step == 3'd1) begin
               r.action_kind = ACT_DEINIT;
            end else begin
               r.action_kind = start_act(step - 3'd2);
            end
            r.last = (step == 3'd5);
         end
         SEQ_SHOW_CONN: begin
            r.action_kind  = ACT_SHOW;
            r.station_code = STN_CONNECTING;
            r.last         = 1'b1;
         end
         SEQ_SHOW_WIFI: begin
            r.action_kind  = ACT_SHOW;
            r.station_code = STN_WIFI_FAIL;
            r.last         = 1'b1;
         end
         SEQ_ERR: begin
            if (step == 3'd0) begin
               r.action_kind = ACT_DEINIT;
            end else begin
               r.action_kind  = ACT_SHOW;
               r.station_code = STN_AUDIO_FAIL;
            end
            r.last = (step == 3'd1);
         end
         SEQ_STOP_IND: begin
            r.action_kind = (step == 3'd0) ? ACT_STOP : ACT_INDICATOR;
            r.last        = (step == 3'd1);
         end
         SEQ_STOP: begin
            r.action_kind = ACT_STOP;
            r.last        = 1'b1;
         end
         default: begin
            r.last = 1'b1;
         end
      endcase
      return r;
   endfunction

   logic [2:0] step_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;
   rsp_type    rsp_data_in;
   logic       load;

   assign rsp_data_in = action_of(q_seq, step_ff);
   assign load        = !q_empty && (!rsp_valid_ff || rsp_pop);
   assign q_pop       = load && rsp_data_in.last;
   assign rsp_empty   = !rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            // advance within the sequence, restart on its last action
            step_ff      <= rsp_data_in.last ? 3'd0 : step_ff + 3'd1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> rsp_data_in.last) else $error("sequence dropped before its last action");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 3'd5) else $error("sequence step out of range");

   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      load && !rsp_data_in.last |=> step_ff == $past(step_ff) + 3'd1)
      else $error("sequence step did not advance");

endmodule

`default_nettype wire

// ===== rtl/core/audio_playback_event_fsm_top.sv =====
// Top level of the audio playback event controller.
// Instantiates apef_front, apef_queue and apef_back; depends on apef_pkg.
//
//   channel   ports                         direction   moves
//   request   req_push / req_full / req_data  in        one event with flags and ticks
//   response  rsp_pop / rsp_empty / rsp_data  out       one action, last marks event end
//   csr       csr_we / csr_index / csr_wdata  in        timeout and stall limit writes
//
// An event is classified and the state updated in the cycle it is accepted, and
// its sequence code enters the queue at that edge. Actions load into rsp_data one
// per cycle while it is empty or being popped, 0 to 6 per event; a sequence code
// leaves the queue only when its last action loads, so a six-action track change
// holds the back end until all six of its actions have loaded.
// Synchronous active-high reset puts the controller in idle with an empty queue.
// A stalled response side backs up into the queue, and req_full rises only when
// the QUEUE_DEPTH sequence codes are all waiting.
`default_nettype none

module audio_playback_event_fsm_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire apef_pkg::req_type                     req_data,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output apef_pkg::rsp_type                          rsp_data,
   input  wire logic                                  csr_we,
   input  wire logic [apef_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [apef_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import apef_pkg::*;

   logic    q_push, q_full, q_pop, q_empty;
   seq_type push_seq, pop_seq;

   apef_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_push    (q_push),
      .q_seq     (push_seq),
      .q_full    (q_full)
   );

   apef_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_seq (push_seq),
      .full     (q_full),
      .pop      (q_pop),
      .pop_seq  (pop_seq),
      .empty    (q_empty)
   );

   apef_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_seq     (pop_seq),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the audio playback event controller.
// Drives events through the request queue, predicts each action list, and
// checks it on the response queue. Depends on apef_pkg and audio_playback_event_fsm_top.
`timescale 1ns / 1ps

module testbench;
   import apef_pkg::*;

   localparam int unsigned QuietLimit = 2000;

   typedef enum logic [3:0] {
      EV_NONE         = 4'd0,
      EV_BTN_TOGGLE   = 4'd1,
      EV_AUTO_PLAY    = 4'd2,
      EV_AGENT_OFF    = 4'd3,
      EV_NET_OK       = 4'd4,
      EV_TICK         = 4'd5,
      EV_PLAYING      = 4'd6,
      EV_PLAYER_ERROR = 4'd7,
      EV_BTN_NEXT     = 4'd8,
      EV_PLAYER_IDLE  = 4'd9,
      EV_PLAYER_NEXT  = 4'd10,
      EV_ALARM_DONE   = 4'd11,
      EV_STOP_DONE    = 4'd12,
      EV_RSVD_A       = 4'd13,
      EV_RSVD_B       = 4'd14,
      EV_RSVD_C       = 4'd15
   } event_code_type;

   typedef enum logic [3:0] {
      ACT_INIT         = 4'd0,
      ACT_FETCH        = 4'd1,
      ACT_PLAY_URL     = 4'd2,
      ACT_ARM_ALARM    = 4'd3,
      ACT_STOP         = 4'd4,
      ACT_DEINIT       = 4'd5,
      ACT_VOLUME       = 4'd6,
      ACT_SHOW_STATION = 4'd7,
      ACT_INDICATOR    = 4'd8
   } action_kind_type;

   typedef enum logic [1:0] {
      STN_NONE          = 2'd0,
      STN_CONNECTING    = 2'd1,
      STN_WIFI_FAILED   = 2'd2,
      STN_AUDIO_FAILURE = 2'd3
   } station_code_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_PENDING  = 3'd1,
      ST_INIT     = 3'd2,
      ST_PLAYING  = 3'd3,
      ST_STOPPING = 3'd4,
      ST_ERROR    = 3'd5
   } player_state_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_PENDING_TIMEOUT = 2'd0,
      REG_STALL_LIMIT     = 2'd1,
      REG_UNUSED_A        = 2'd2,
      REG_UNUSED_B        = 2'd3
   } reg_index_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   req_type                  req_data = '0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   player_state_type player_state = ST_IDLE;
   logic [15:0]      pending_limit = 16'd30;
   logic [15:0]      stall_limit = 16'd3;
   rsp_type          expected_actions[$];
   rsp_type          event_actions[$];
   int unsigned      mismatches = 0;
   int unsigned      quiet_cycles = 0;
   bit               no_idle = 1'b0;

   audio_playback_event_fsm_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------- prediction ----------------

   function void push_act(action_kind_type kind, station_code_type code);
      rsp_type act;
      act.action_kind  = kind;
      act.station_code = code;
      act.indicator_on = 1'b0;
      act.last         = 1'b0;
      event_actions.push_back(act);
   endfunction

   function void add_start();
      push_act(ACT_INIT, STN_NONE);
      push_act(ACT_FETCH, STN_NONE);
      push_act(ACT_PLAY_URL, STN_NONE);
      push_act(ACT_ARM_ALARM, STN_NONE);
   endfunction

   function void add_track_change();
      push_act(ACT_STOP, STN_NONE);
      push_act(ACT_DEINIT, STN_NONE);
      add_start();
   endfunction

   function void add_audio_failure();
      push_act(ACT_DEINIT, STN_NONE);
      push_act(ACT_SHOW_STATION, STN_AUDIO_FAILURE);
   endfunction

   function void predict_actions(req_type item);
      event_actions.delete();
      case (player_state)
         ST_IDLE: begin
            if (item.func == EV_BTN_TOGGLE) begin
               if (item.agent_on && item.link_up) begin
                  player_state = ST_INIT;
                  add_start();
               end else if (item.agent_on) begin
                  player_state = ST_PENDING;
                  push_act(ACT_SHOW_STATION, STN_CONNECTING);
               end
            end else if (item.func == EV_AUTO_PLAY) begin
               player_state = ST_INIT;
               push_act(ACT_VOLUME, STN_NONE);
               add_start();
            end
         end
         ST_PENDING: begin
            if (item.func == EV_NET_OK) begin
               player_state = ST_INIT;
               add_start();
            end else if (item.func == EV_TICK && item.wait_ticks >= pending_limit) begin
               player_state = ST_ERROR;
               push_act(ACT_SHOW_STATION, STN_WIFI_FAILED);
            end else if (item.func == EV_BTN_TOGGLE) begin
               player_state = ST_IDLE;
            end
         end
         ST_INIT: begin
            if (item.func == EV_PLAYING) begin
               player_state = ST_PLAYING;
            end else if (item.func == EV_PLAYER_ERROR) begin
               player_state = ST_ERROR;
               add_audio_failure();
            end
         end
         ST_PLAYING: begin
            if (item.func == EV_BTN_TOGGLE) begin
               player_state = ST_STOPPING;
               push_act(ACT_STOP, STN_NONE);
               push_act(ACT_INDICATOR, STN_NONE);
            end else if (item.func == EV_BTN_NEXT || item.func == EV_PLAYER_IDLE ||
                         item.func == EV_PLAYER_NEXT) begin
               add_track_change();
            end else if (item.func == EV_PLAYER_ERROR) begin
               player_state = ST_ERROR;
               add_audio_failure();
            end else if (item.func == EV_ALARM_DONE) begin
               player_state = ST_STOPPING;
               push_act(ACT_STOP, STN_NONE);
            end else if (item.func == EV_TICK && item.stall_count >= stall_limit) begin
               add_track_change();
            end
         end
         ST_STOPPING: begin
            if (item.func == EV_STOP_DONE) player_state = ST_IDLE;
         end
         ST_ERROR: begin
            if (item.func == EV_BTN_TOGGLE) begin
               player_state = ST_INIT;
               add_start();
            end
         end
         default: ;
      endcase
      if (event_actions.size() != 0) event_actions[event_actions.size() - 1].last = 1'b1;
      foreach (event_actions[i]) expected_actions.push_back(event_actions[i]);
   endfunction

   // ---------------- request side ----------------

   function automatic req_type make_event(logic [3:0] func, logic agent, logic net,
                                          logic [15:0] pticks, logic [15:0] sticks);
      req_type item;
      item.func        = func;
      item.agent_on    = agent;
      item.link_up     = net;
      item.wait_ticks  = pticks;
      item.stall_count = sticks;
      return item;
   endfunction

   function int unsigned draw_idle();
      if (no_idle || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 19);
   endfunction

   task automatic send_event(req_type item);
      int unsigned gap;
      gap = draw_idle();
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= item;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_actions(item);
   endtask

   // Hold requests until every predicted action has come out.
   task automatic wait_for_actions();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type index, logic [15:0] value);
      wait_for_actions();
      csr_index <= index;
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == REG_PENDING_TIMEOUT) pending_limit = value;
      else if (index == REG_STALL_LIMIT) stall_limit = value;
   endtask

   // ---------------- response side ----------------

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function void check_action(rsp_type got);
      rsp_type want;
      if (expected_actions.size() == 0) begin
         $display("%0t: unexpected action, expected none actual kind %0d code %0d last %0d",
                  $time, got.action_kind, got.station_code, got.last);
         mismatches++;
      end else begin
         want = expected_actions.pop_front();
         compare_field("action_kind", want.action_kind, got.action_kind);
         compare_field("station_code", want.station_code, got.station_code);
         compare_field("indicator_on", want.indicator_on, got.indicator_on);
         compare_field("last", want.last, got.last);
      end
   endfunction

   initial begin
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_idle();
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         check_action(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no progress for %0d cycles, %0d actions outstanding",
                  $time, quiet_cycles, expected_actions.size());
         $display("** audio_playback_event_fsm_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- tests ----------------

   task automatic test_idle_events();
      send_event(make_event(EV_NONE, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
      send_event(make_event(EV_RSVD_C, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
      send_event(make_event(EV_BTN_TOGGLE, 1'b0, 1'b1, 16'h0000, 16'h0000));
      // auto play starts even with the agent disabled
      send_event(make_event(EV_AUTO_PLAY, 1'b0, 1'b0, 16'h0000, 16'h0000));
   endtask

   task automatic test_init_events();
      send_event(make_event(EV_PLAYER_ERROR, 1'b0, 1'b0, 16'h0000, 16'h0000));
      send_event(make_event(EV_BTN_TOGGLE, 1'b0, 1'b0, 16'h0000, 16'h0000));
      send_event(make_event(EV_PLAYING, 1'b0, 1'b0, 16'h0000, 16'h0000));
   endtask

   task automatic test_playing_events();
      send_event(make_event(EV_TICK, 1'b1, 1'b1, 16'hFFFF, 16'd2));
      send_event(make_event(EV_TICK, 1'b1, 1'b1, 16'h0000, 16'd3));
      send_event(make_event(EV_BTN_NEXT, 1'b1, 1'b1, 16'h0000, 16'h0000));
      send_event(make_event(EV_PLAYER_IDLE, 1'b1, 1'b1, 16'h0000, 16'h0000));
      send_event(make_event(EV_PLAYER_NEXT, 1'b1, 1'b1, 16'h0000, 16'h0000));
      send_event(make_event(EV_PLAYER_ERROR, 1'b1, 1'b1, 16'h0000, 16'h0000));
      send_event(make_event(EV_BTN_TOGGLE, 1'b1, 1'b1, 16'h0000, 16'h0000));
      send_event(make_event(EV_PLAYING, 1'b1, 1'b1, 16'h0000, 16'h0000));
      send_event(make_event(EV_ALARM_DONE, 1'b1, 1'b1, 16'h0000, 16'h0000));
      send_event(make_event(EV_STOP_DONE, 1'b1, 1'b1, 16'h0000, 16'h0000));
   endtask

   task automatic test_pending_events();
      send_event(make_event(EV_BTN_TOGGLE, 1'b1, 1'b0, 16'h0000, 16'h0000));
      send_event(make_event(EV_NET_OK, 1'b1, 1'b1, 16'h0000, 16'h0000));
      send_event(make_event(EV_PLAYING, 1'b1, 1'b1, 16'h0000, 16'h0000));
      send_event(make_event(EV_BTN_TOGGLE, 1'b1, 1'b1, 16'h0000, 16'h0000));
      send_event(make_event(EV_STOP_DONE, 1'b1, 1'b1, 16'h0000, 16'h0000));
      send_event(make_event(EV_BTN_TOGGLE, 1'b1, 1'b0, 16'h0000, 16'h0000));
      // button in pending returns to idle silently
      send_event(make_event(EV_BTN_TOGGLE, 1'b1, 1'b0, 16'h0000, 16'h0000));
      send_event(make_event(EV_BTN_TOGGLE, 1'b1, 1'b0, 16'h0000, 16'h0000));
      wait_for_actions();
      send_event(make_event(EV_TICK, 1'b1, 1'b0, 16'd29, 16'hFFFF));
      send_event(make_event(EV_TICK, 1'b1, 1'b0, 16'd30, 16'h0000));
   endtask

   task automatic test_registers();
      // indexes past the stall limit must not touch either threshold
      write_reg(REG_UNUSED_A, 16'h0000);
      write_reg(REG_UNUSED_B, 16'h0000);
      write_reg(REG_STALL_LIMIT, 16'hFFFF);
      write_reg(REG_PENDING_TIMEOUT, 16'hFFFF);
      send_event(make_event(EV_BTN_TOGGLE, 1'b0, 1'b0, 16'h0000, 16'h0000));
      send_event(make_event(EV_PLAYING, 1'b0, 1'b0, 16'h0000, 16'h0000));
      send_event(make_event(EV_TICK, 1'b0, 1'b0, 16'h0000, 16'hFFFE));
      send_event(make_event(EV_TICK, 1'b0, 1'b0, 16'h0000, 16'hFFFF));
      write_reg(REG_STALL_LIMIT, 16'h0000);
      send_event(make_event(EV_TICK, 1'b0, 1'b0, 16'h0000, 16'h0000));
   endtask

   function logic [3:0] pick_func();
      if ($urandom_range(0, 9) < 2) return 4'($urandom_range(0, 15));
      case (player_state)
         ST_IDLE:     return ($urandom_range(0, 2) == 0) ? EV_AUTO_PLAY : EV_BTN_TOGGLE;
         ST_PENDING: begin
            case ($urandom_range(0, 4))
               0:       return EV_NET_OK;
               1:       return EV_BTN_TOGGLE;
               default: return EV_TICK;
            endcase
         end
         ST_INIT:     return ($urandom_range(0, 3) == 0) ? EV_PLAYER_ERROR : EV_PLAYING;
         ST_PLAYING: begin
            case ($urandom_range(0, 9))
               0:       return EV_BTN_TOGGLE;
               1:       return EV_BTN_NEXT;
               2:       return EV_PLAYER_IDLE;
               3:       return EV_PLAYER_NEXT;
               4:       return EV_PLAYER_ERROR;
               5:       return EV_ALARM_DONE;
               default: return EV_TICK;
            endcase
         end
         ST_STOPPING: return EV_STOP_DONE;
         ST_ERROR:    return EV_BTN_TOGGLE;
         default:     return EV_NONE;
      endcase
   endfunction

   // Land tick counts on and around the threshold half of the time, else at the extremes or at random.
   function logic [15:0] pick_ticks(logic [15:0] limit);
      case ($urandom_range(0, 5))
         0:       return limit;
         1:       return (limit == 16'h0000) ? limit : limit - 16'd1;
         2:       return (limit == 16'hFFFF) ? limit : limit + 16'd1;
         3:       return 16'h0000;
         4:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic test_random_traffic();
      req_type item;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_PENDING_TIMEOUT, 16'($urandom_range(0, 40)));
               write_reg(REG_STALL_LIMIT, 16'($urandom_range(0, 8)));
            end
            1: begin
               write_reg(REG_PENDING_TIMEOUT, 16'h0000);
               write_reg(REG_STALL_LIMIT, 16'h0000);
               no_idle = 1'b1;
            end
            2: begin
               write_reg(REG_PENDING_TIMEOUT, 16'hFFFF);
               write_reg(REG_STALL_LIMIT, 16'hFFFF);
               no_idle = 1'b0;
            end
            default: begin
               write_reg(REG_PENDING_TIMEOUT, 16'($urandom_range(0, 65535)));
               write_reg(REG_STALL_LIMIT, 16'($urandom_range(0, 65535)));
            end
         endcase
         for (int n = 0; n < 18; n++) begin
            item = make_event(pick_func(), ($urandom_range(0, 3) != 0), 1'($urandom),
                              pick_ticks(pending_limit), pick_ticks(stall_limit));
            send_event(item);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_events();
      test_init_events();
      test_playing_events();
      test_pending_events();
      test_registers();
      test_random_traffic();
      wait_for_actions();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && expected_actions.size() == 0) begin
         $display("** audio_playback_event_fsm_top: PASSED **");
      end else begin
         $display("** audio_playback_event_fsm_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/apef_pkg.sv
rtl/core/apef_front.sv
rtl/core/apef_queue.sv
rtl/core/apef_back.sv
rtl/core/audio_playback_event_fsm_top.sv
sim/testbench.sv
